// ===== design/rv32_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rv32_pkg;
    localparam int XLEN = 32;
    localparam int FUNC_W = 5;
    localparam int TAG_W = 3;
    // number of divider cells, one per quotient bit; the entry and exit stages come on top
    localparam int DIV_CELLS = XLEN;

    localparam logic [FUNC_W-1:0] F_ADD = 5'd0;
    localparam logic [FUNC_W-1:0] F_SUB = 5'd1;
    localparam logic [FUNC_W-1:0] F_AND = 5'd2;
    localparam logic [FUNC_W-1:0] F_OR = 5'd3;
    localparam logic [FUNC_W-1:0] F_XOR = 5'd4;
    localparam logic [FUNC_W-1:0] F_SLL = 5'd5;
    localparam logic [FUNC_W-1:0] F_SRL = 5'd6;
    localparam logic [FUNC_W-1:0] F_SRA = 5'd7;
    localparam logic [FUNC_W-1:0] F_SLT = 5'd8;
    localparam logic [FUNC_W-1:0] F_SLTU = 5'd9;
    localparam logic [FUNC_W-1:0] F_MUL = 5'd10;
    localparam logic [FUNC_W-1:0] F_MULH = 5'd11;
    localparam logic [FUNC_W-1:0] F_MULHSU = 5'd12;
    localparam logic [FUNC_W-1:0] F_MULHU = 5'd13;
    localparam logic [FUNC_W-1:0] F_DIV = 5'd14;
    localparam logic [FUNC_W-1:0] F_DIVU = 5'd15;
    localparam logic [FUNC_W-1:0] F_REM = 5'd16;
    localparam logic [FUNC_W-1:0] F_REMU = 5'd17;
    localparam logic [FUNC_W-1:0] F_BEQ = 5'd18;
    localparam logic [FUNC_W-1:0] F_BNE = 5'd19;
    localparam logic [FUNC_W-1:0] F_BLT = 5'd20;
    localparam logic [FUNC_W-1:0] F_BGE = 5'd21;
    localparam logic [FUNC_W-1:0] F_BLTU = 5'd22;
    localparam logic [FUNC_W-1:0] F_BGEU = 5'd23;
    localparam logic [FUNC_W-1:0] F_JAL = 5'd24;
    localparam logic [FUNC_W-1:0] F_JALR = 5'd25;
    localparam logic [FUNC_W-1:0] F_AUIPC = 5'd26;
    localparam logic [FUNC_W-1:0] F_LUI = 5'd27;

    // how the last stage builds the result
    localparam logic [TAG_W-1:0] K_PLAIN = 3'd0;
    localparam logic [TAG_W-1:0] K_MULLO = 3'd1;
    localparam logic [TAG_W-1:0] K_MULHI = 3'd2;
    localparam logic [TAG_W-1:0] K_QUOT = 3'd3;
    localparam logic [TAG_W-1:0] K_REM = 3'd4;

    localparam logic [XLEN-1:0] JALR_MASK = 32'hFFFF_FFFE;
    localparam logic [XLEN-1:0] INSN_BYTES = 32'd4;

    // state carried from cell to cell along the chain
    typedef struct packed {
        logic             vld;
        logic [TAG_W-1:0] kind;
        logic             neg_q;   // negate quotient / product at the end
        logic             neg_r;   // negate remainder at the end
        logic             fixed;   // result already known (div by zero, overflow, alu)
        logic [XLEN-1:0]  res;
        logic             taken;
        logic [XLEN-1:0]  target;
        logic [XLEN-1:0]  rem;     // partial remainder
        logic [XLEN-1:0]  quo;     // dividend shifting out, quotient shifting in
        logic [XLEN-1:0]  dvs;     // divisor magnitude
        logic [2*XLEN-1:0] prod;   // multiplier product magnitude
    } t_cell;
endpackage
`default_nettype wire

// ===== design/rv32im_execute_unit_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// RV32IM integer execute unit built as a chain of cells. Every transaction enters
// a decode/ALU cell (which also does branches, jumps, the signed-magnitude setup
// and a registered 32x32 multiply), then passes through 32 identical divider
// cells, one quotient bit each, then a result cell that applies signs and
// selects the product half, quotient or remainder. There are 34 register stages
// for every operation, and one transaction is accepted every cycle unless the
// output holds a stalled result. The whole chain advances together whenever
// the output is not stalled or its last cell is empty, so a stall at the
// output holds every cell in place. Results leave in order. No configuration,
// no clearing pass after reset.
module rv32im_execute_unit_top
    import rv32_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic              i_use_imm,
    input  wire logic [XLEN-1:0]   i_operand_a,
    input  wire logic [XLEN-1:0]   i_operand_b,
    input  wire logic [XLEN-1:0]   i_imm,
    input  wire logic [XLEN-1:0]   i_pc_value,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [XLEN-1:0]        o_result,
    output logic                   o_branch_taken,
    output logic [XLEN-1:0]        o_branch_target
);
    logic w_en;
    t_cell w_chain [0:DIV_CELLS];

    // the chain moves when the output register is free or being drained
    assign w_en = !(o_valid && i_stall);
    assign o_stall = !w_en;

    rv32_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(i_valid), .i_func(i_func), .i_use_imm(i_use_imm),
        .i_a(i_operand_a), .i_b(i_operand_b), .i_imm(i_imm), .i_pc(i_pc_value),
        .o_cell(w_chain[0])
    );

    // one restoring-division cell per quotient bit
    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        rv32_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_cell(w_chain[g]), .o_cell(w_chain[g+1])
        );
    end

    rv32_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_cell(w_chain[DIV_CELLS]),
        .o_vld(o_valid), .o_res(o_result),
        .o_taken(o_branch_taken), .o_target(o_branch_target)
    );

`ifndef SYNTHESIS
    // a stalled result must stay put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result changed under stall");
    // output side drives input stall only through its own stall
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");
    // not-taken means no target
    a_tgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_branch_taken |-> o_branch_target == '0)
        else $error("target without taken branch");
`endif
endmodule
`default_nettype wire

// ===== design/rv32_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rv32_div_cell
    import rv32_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_cell i_cell,
    output t_cell      o_cell
);
    t_cell r_cell;
    t_cell n_cell;
    logic [XLEN:0] w_trial;
    logic [XLEN:0] w_diff;

    // one restoring division step per cell
    always_comb begin
        n_cell = i_cell;
        w_trial = {i_cell.rem, i_cell.quo[XLEN-1]};
        w_diff = w_trial - {1'b0, i_cell.dvs};
        if (!w_diff[XLEN]) begin
            n_cell.rem = w_diff[XLEN-1:0];
            n_cell.quo = {i_cell.quo[XLEN-2:0], 1'b1};
        end else begin
            n_cell.rem = w_trial[XLEN-1:0];
            n_cell.quo = {i_cell.quo[XLEN-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= i_cell.vld;
        end
        if (i_en) begin
            r_cell.kind <= n_cell.kind;
            r_cell.neg_q <= n_cell.neg_q;
            r_cell.neg_r <= n_cell.neg_r;
            r_cell.fixed <= n_cell.fixed;
            r_cell.res <= n_cell.res;
            r_cell.taken <= n_cell.taken;
            r_cell.target <= n_cell.target;
            r_cell.rem <= n_cell.rem;
            r_cell.quo <= n_cell.quo;
            r_cell.dvs <= n_cell.dvs;
            r_cell.prod <= n_cell.prod;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

// ===== design/rv32_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rv32_front
    import rv32_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic              i_use_imm,
    input  wire logic [XLEN-1:0]   i_a,
    input  wire logic [XLEN-1:0]   i_b,
    input  wire logic [XLEN-1:0]   i_imm,
    input  wire logic [XLEN-1:0]   i_pc,
    output t_cell                  o_cell
);
    t_cell r_cell;
    t_cell n_cell;
    logic [XLEN-1:0] w_op2;
    logic [4:0] w_sh;
    logic w_lts, w_ltu, w_lts_b, w_ltu_b, w_cond, w_br;
    logic w_sa, w_sb;
    logic [XLEN-1:0] w_ma, w_mb;
    logic [2*XLEN-1:0] w_sra;

    always_comb begin
        w_op2 = i_use_imm ? i_imm : i_b;
        w_sh = w_op2[4:0];
        w_lts = $signed(i_a) < $signed(w_op2);
        w_ltu = i_a < w_op2;
        w_lts_b = $signed(i_a) < $signed(i_b);
        w_ltu_b = i_a < i_b;
        w_sra = {{XLEN{i_a[XLEN-1]}}, i_a} >> w_sh;
        w_sa = 1'b0;
        w_sb = 1'b0;
        w_cond = 1'b0;
        w_br = 1'b0;
        n_cell = '0;
        n_cell.vld = i_vld;
        n_cell.kind = K_PLAIN;
        n_cell.fixed = 1'b1;
        unique case (i_func) inside
            F_ADD: n_cell.res = i_a + w_op2;
            F_SUB: n_cell.res = i_a - w_op2;
            F_AND: n_cell.res = i_a & w_op2;
            F_OR: n_cell.res = i_a | w_op2;
            F_XOR: n_cell.res = i_a ^ w_op2;
            F_SLL: n_cell.res = i_a << w_sh;
            F_SRL: n_cell.res = i_a >> w_sh;
            F_SRA: n_cell.res = w_sra[XLEN-1:0];
            F_SLT: n_cell.res = {{(XLEN-1){1'b0}}, w_lts};
            F_SLTU: n_cell.res = {{(XLEN-1){1'b0}}, w_ltu};
            F_MUL, F_MULH, F_MULHSU, F_MULHU: begin
                n_cell.kind = (i_func == F_MUL) ? K_MULLO : K_MULHI;
                n_cell.fixed = 1'b0;
                w_sa = (i_func == F_MULH || i_func == F_MULHSU) && i_a[XLEN-1];
                w_sb = (i_func == F_MULH) && i_b[XLEN-1];
            end
            F_DIV, F_DIVU, F_REM, F_REMU: begin
                n_cell.kind = (i_func == F_DIV || i_func == F_DIVU) ? K_QUOT : K_REM;
                w_sa = (i_func == F_DIV || i_func == F_REM) && i_a[XLEN-1];
                w_sb = (i_func == F_DIV || i_func == F_REM) && i_b[XLEN-1];
                if (i_b == '0) begin
                    n_cell.res = (n_cell.kind == K_QUOT) ? '1 : i_a;
                end else if ((i_func == F_DIV || i_func == F_REM) &&
                             i_a == {1'b1, {(XLEN-1){1'b0}}} && i_b == '1) begin
                    n_cell.res = (n_cell.kind == K_QUOT) ? i_a : '0;
                end else begin
                    n_cell.fixed = 1'b0;
                end
            end
            F_BEQ: begin w_br = 1'b1; w_cond = i_a == i_b; end
            F_BNE: begin w_br = 1'b1; w_cond = i_a != i_b; end
            F_BLT: begin w_br = 1'b1; w_cond = w_lts_b; end
            F_BGE: begin w_br = 1'b1; w_cond = !w_lts_b; end
            F_BLTU: begin w_br = 1'b1; w_cond = w_ltu_b; end
            F_BGEU: begin w_br = 1'b1; w_cond = !w_ltu_b; end
            F_JAL: begin
                n_cell.taken = 1'b1;
                n_cell.target = i_pc + i_imm;
                n_cell.res = i_pc + INSN_BYTES;
            end
            F_JALR: begin
                n_cell.taken = 1'b1;
                n_cell.target = (i_a + i_imm) & JALR_MASK;
                n_cell.res = i_pc + INSN_BYTES;
            end
            F_AUIPC: n_cell.res = i_pc + i_imm;
            F_LUI: n_cell.res = i_imm;
            default: n_cell.res = '0;
        endcase
        if (w_br && w_cond) begin
            n_cell.taken = 1'b1;
            n_cell.target = i_pc + i_imm;
        end
        w_ma = w_sa ? (~i_a + 1'b1) : i_a;
        w_mb = w_sb ? (~i_b + 1'b1) : i_b;
        n_cell.neg_q = w_sa ^ w_sb;
        n_cell.neg_r = w_sa;
        n_cell.quo = w_ma;
        n_cell.dvs = w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= n_cell.vld;
        end
        if (i_en) begin
            r_cell.kind <= n_cell.kind;
            r_cell.neg_q <= n_cell.neg_q;
            r_cell.neg_r <= n_cell.neg_r;
            r_cell.fixed <= n_cell.fixed;
            r_cell.res <= n_cell.res;
            r_cell.taken <= n_cell.taken;
            r_cell.target <= n_cell.target;
            r_cell.rem <= n_cell.rem;
            r_cell.quo <= n_cell.quo;
            r_cell.dvs <= n_cell.dvs;
            // unsigned 32x32 magnitude product, one multiplier, registered
            r_cell.prod <= {{XLEN{1'b0}}, w_ma} * {{XLEN{1'b0}}, w_mb};
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

// ===== design/rv32_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rv32_back
    import rv32_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire t_cell           i_cell,
    output logic                 o_vld,
    output logic [XLEN-1:0]      o_res,
    output logic                 o_taken,
    output logic [XLEN-1:0]      o_target
);
    logic r_vld;
    logic [XLEN-1:0] r_res, r_target;
    logic r_taken;
    logic [XLEN-1:0] n_res;
    logic [2*XLEN-1:0] w_p;

    always_comb begin
        w_p = i_cell.neg_q ? (~i_cell.prod + 1'b1) : i_cell.prod;
        n_res = i_cell.res;
        if (!i_cell.fixed) begin
            case (i_cell.kind)
                K_MULLO: n_res = w_p[XLEN-1:0];
                K_MULHI: n_res = w_p[2*XLEN-1:XLEN];
                K_QUOT: n_res = i_cell.neg_q ? (~i_cell.quo + 1'b1) : i_cell.quo;
                K_REM: n_res = i_cell.neg_r ? (~i_cell.rem + 1'b1) : i_cell.rem;
                default: n_res = i_cell.res;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_cell.vld;
        end
        if (i_en) begin
            r_res <= n_res;
            r_taken <= i_cell.taken;
            r_target <= i_cell.target;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;
    assign o_taken = r_taken;
    assign o_target = r_target;
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import rv32_pkg::*;

    // codes with no operation behind them
    localparam logic [FUNC_W-1:0] F_UNUSED_LO = 5'd28;
    localparam logic [FUNC_W-1:0] F_UNUSED_HI = 5'd31;

    typedef struct packed {
        logic [XLEN-1:0] result;
        logic            taken;
        logic [XLEN-1:0] target;
    } t_exec_out;

    // in-order store of predicted execute results
    class exec_scoreboard;
        t_exec_out pending[$];
        int        errors;
        int        checked;
        int        n_taken;

        function t_exec_out compute(logic [FUNC_W-1:0] fn, logic ui,
                                    logic [XLEN-1:0] a, logic [XLEN-1:0] b,
                                    logic [XLEN-1:0] im, logic [XLEN-1:0] pc);
            t_exec_out        r;
            logic [XLEN-1:0]  op2;
            logic [4:0]       sh;
            logic [63:0]      p;
            logic             cond;
            r    = '0;
            op2  = ui ? im : b;
            sh   = op2[4:0];
            cond = 1'b0;
            case (fn)
                F_ADD:    r.result = a + op2;
                F_SUB:    r.result = a - op2;
                F_AND:    r.result = a & op2;
                F_OR:     r.result = a | op2;
                F_XOR:    r.result = a ^ op2;
                F_SLL:    r.result = a << sh;
                F_SRL:    r.result = a >> sh;
                F_SRA:    r.result = $unsigned($signed(a) >>> sh);
                F_SLT:    r.result = {31'd0, $signed(a) < $signed(op2)};
                F_SLTU:   r.result = {31'd0, a < op2};
                F_MUL:    r.result = a * b;
                F_MULH: begin
                    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    r.result = p[63:32];
                end
                F_MULHSU: begin
                    p = {{32{a[31]}}, a} * {32'd0, b};
                    r.result = p[63:32];
                end
                F_MULHU: begin
                    p = {32'd0, a} * {32'd0, b};
                    r.result = p[63:32];
                end
                F_DIV: begin
                    if (b == '0) r.result = '1;
                    else if (a == 32'h8000_0000 && b == '1) r.result = a;
                    else r.result = $unsigned($signed(a) / $signed(b));
                end
                F_DIVU:   r.result = (b == '0) ? '1 : a / b;
                F_REM: begin
                    if (b == '0) r.result = a;
                    else if (a == 32'h8000_0000 && b == '1) r.result = '0;
                    else r.result = $unsigned($signed(a) % $signed(b));
                end
                F_REMU:   r.result = (b == '0) ? a : a % b;
                F_BEQ:    cond = (a == b);
                F_BNE:    cond = (a != b);
                F_BLT:    cond = $signed(a) < $signed(b);
                F_BGE:    cond = !($signed(a) < $signed(b));
                F_BLTU:   cond = a < b;
                F_BGEU:   cond = a >= b;
                F_JAL: begin
                    r.taken  = 1'b1;
                    r.target = pc + im;
                    r.result = pc + INSN_BYTES;
                end
                F_JALR: begin
                    r.taken  = 1'b1;
                    r.target = (a + im) & JALR_MASK;
                    r.result = pc + INSN_BYTES;
                end
                F_AUIPC:  r.result = pc + im;
                F_LUI:    r.result = im;
                default:  r = '0;
            endcase
            if (cond) begin
                r.taken  = 1'b1;
                r.target = pc + im;
            end
            return r;
        endfunction

        function void note_issue(logic [FUNC_W-1:0] fn, logic ui, logic [XLEN-1:0] a,
                                 logic [XLEN-1:0] b, logic [XLEN-1:0] im,
                                 logic [XLEN-1:0] pc);
            pending.push_back(compute(fn, ui, a, b, im, pc));
        endfunction

        task report(string what, logic [XLEN-1:0] got, logic [XLEN-1:0] exp);
            $display("mismatch %s: got %h expected %h", what, got, exp);
            errors++;
        endtask

        // compare one accepted result against the oldest prediction
        task check_result(logic [XLEN-1:0] res, logic taken, logic [XLEN-1:0] target);
            t_exec_out e;
            if (pending.size() == 0) begin
                report("unexpected result", res, '0);
            end else begin
                e = pending.pop_front();
                checked++;
                if (res !== e.result) report("result", res, e.result);
                if (taken !== e.taken)
                    report("taken", {31'd0, taken}, {31'd0, e.taken});
                if (target !== e.target) report("target", target, e.target);
                if (e.taken) n_taken++;
            end
        endtask
    endclass

    exec_scoreboard sb;
    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [FUNC_W-1:0] i_func = '0;
    logic             i_use_imm = 1'b0;
    logic [XLEN-1:0]  i_operand_a = '0;
    logic [XLEN-1:0]  i_operand_b = '0;
    logic [XLEN-1:0]  i_imm = '0;
    logic [XLEN-1:0]  i_pc_value = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [XLEN-1:0]  o_result;
    logic             o_branch_taken;
    logic [XLEN-1:0]  o_branch_target;

    int  idle_cycles = 0;
    bit  sink_calm = 1'b0;     // no random stalls on the result side
    bit  hold_off = 1'b0;      // long receiver hold-off in progress
    bit  src_calm = 1'b0;
    int  n_issued = 0;

    localparam int LATENCY = 34;
    localparam int WATCHDOG = 2000;

    always #5 i_clk = ~i_clk;

    rv32im_execute_unit_top dut (.*);

    // offer one instruction, hold it until accepted, maybe idle afterwards
    task automatic issue(logic [FUNC_W-1:0] fn, logic ui, logic [XLEN-1:0] a,
                         logic [XLEN-1:0] b, logic [XLEN-1:0] im, logic [XLEN-1:0] pc);
        i_valid     <= 1'b1;
        i_func      <= fn;
        i_use_imm   <= ui;
        i_operand_a <= a;
        i_operand_b <= b;
        i_imm       <= im;
        i_pc_value  <= pc;
        do @(posedge i_clk); while (o_stall);
        sb.note_issue(fn, ui, a, b, im, pc);
        n_issued++;
        if (!src_calm) begin
            while ($urandom_range(99) < 23) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [XLEN-1:0] corner_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            5: return $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // result side: random stalls, checks on every accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_result(o_result, o_branch_taken, o_branch_target);
            end
            i_stall <= hold_off || (!sink_calm && $urandom_range(99) < 23);
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [FUNC_W-1:0] fn;
        int                hold;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: div special cases, shifts, sub with imm, other codes
        issue(F_DIV, 1'b0, 32'h8000_0000, '1, '0, '0);
        issue(F_REM, 1'b0, 32'h8000_0000, '1, '0, '0);
        issue(F_DIV, 1'b0, 32'h1234_5678, '0, '0, '0);
        issue(F_DIVU, 1'b0, '1, '0, '0, '0);
        issue(F_REM, 1'b0, 32'hDEAD_BEEF, '0, '0, '0);
        issue(F_REMU, 1'b0, 32'hCAFE_0001, '0, '0, '0);
        issue(F_SLL, 1'b0, '1, 32'hFFFF_FFE3, '0, '0);
        issue(F_SRA, 1'b1, 32'h8000_0000, '0, 32'hFFFF_FFFF, '0);
        issue(F_SRL, 1'b1, '1, '0, 32'h0000_0020, '0);
        issue(F_SUB, 1'b1, 32'd5, 32'd99, 32'hFFFF_FFFF, '0);
        issue(F_MULH, 1'b0, 32'h8000_0000, 32'h8000_0000, '0, '0);
        issue(F_MULHSU, 1'b0, '1, '1, '0, '0);
        issue(F_MULHU, 1'b0, '1, '1, '0, '0);
        issue(F_BEQ, 1'b0, 32'd7, 32'd7, 32'hFFFF_FFF0, 32'h100);
        issue(F_BNE, 1'b0, 32'd7, 32'd7, 32'd16, 32'h100);
        issue(F_BLT, 1'b0, 32'h8000_0000, '0, 32'd8, '1);
        issue(F_BGEU, 1'b0, '0, '1, 32'd8, '0);
        issue(F_JAL, 1'b1, '0, '0, 32'h7FFF_FFFF, 32'hFFFF_FFFC);
        issue(F_JALR, 1'b0, 32'h1001, '0, 32'h0000_0002, 32'h40);
        issue(F_AUIPC, 1'b0, '0, '0, 32'h8000_0000, 32'h8000_0000);
        issue(F_LUI, 1'b1, '1, '1, 32'hABCD_E000, '0);
        issue(F_UNUSED_LO, 1'b0, '1, '1, '1, '1);
        issue(F_UNUSED_HI, 1'b1, '1, '1, '1, '1);
        issue(F_SLT, 1'b1, 32'h7FFF_FFFF, '0, 32'h8000_0000, '0);
        issue(F_SLTU, 1'b1, '0, '0, '1, '0);

        // random part; a calm stretch in the middle, two pressure points
        for (int k = 0; k < 900; k++) begin
            src_calm  = (k >= 300 && k < 450);
            sink_calm = (k >= 300 && k < 450);
            if (k == 500) begin
                // sender waits for the pipe to drain completely
                go_idle();
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            if (k == 600) begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        hold_off = 1'b1;
                        hold = 0;
                        while (hold < 150) begin
                            @(posedge i_clk);
                            hold++;
                        end
                        hold_off = 1'b0;
                    end
                join_none
            end
            fn = ($urandom_range(19) == 0) ?
                     5'($urandom_range(F_UNUSED_LO, F_UNUSED_HI)) :
                     5'($urandom_range(F_LUI));
            issue(fn, 1'($urandom), corner_word(), corner_word(), corner_word(),
                  corner_word());
        end
        go_idle();

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d instructions over every code incl. unused ones, %0d checked, %0d taken",
                 n_issued, sb.checked, sb.n_taken);
        $display("divide corner cases, shift masking, stalls and a full-pipe hold-off exercised");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
